// ===== sv/lpa_pkg.sv =====
// Package for the log-detector power meter: widths, types, command codes and constant tables.
`default_nettype none
package lpa_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int EXP_FRAC_BITS = 16;
	localparam int ROOT_BITS     = 28;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// exact exponent sum in Q.32, its floored Q.EXP_FRAC_BITS form, and the centi-dBm numerator
	localparam int PROD_W = SAMPLE_BITS + 32;
	localparam int SUM_W  = (((SAMPLE_BITS + 33) > 40) ? (SAMPLE_BITS + 33) : 40) + 1;
	localparam int DROP   = 32 - EXP_FRAC_BITS;
	localparam int LQ_W   = SUM_W - DROP;
	localparam int N_W    = LQ_W - 1 - EXP_FRAC_BITS;
	localparam int D_W    = LQ_W + 11;
	localparam int Q_W    = D_W - EXP_FRAC_BITS;
	localparam int CMP_W  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

	localparam int K_W = $clog2(EXP_FRAC_BITS);
	localparam logic [K_W-1:0] K_LAST = K_W'(EXP_FRAC_BITS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DPC_R0    = 3'd0,
		REG_DPC_R1    = 3'd1,
		REG_ICPT_R0   = 3'd2,
		REG_ICPT_R1   = 3'd3,
		REG_AUTO      = 3'd4,
		REG_MANUAL    = 3'd5,
		REG_UPPER_THR = 3'd6,
		REG_LOWER_THR = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0]        dpc_r0;
		logic [31:0]        dpc_r1;
		logic signed [23:0] icpt_r0;
		logic signed [23:0] icpt_r1;
		logic               auto_range;
		logic               manual_range;
		logic [15:0]        upper_thr;
		logic [15:0]        lower_thr;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PROD,
		OP_SUM,
		OP_DBM,
		OP_EXP,
		OP_SCALE
	} dp_op_t;

	typedef struct packed {
		logic           load;
		dp_op_t         op;
		logic [K_W-1:0] k;
	} cmd_t;

	typedef logic [EXP_FRAC_BITS-1:0][31:0] root_rom_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x   = x_in;
		res = '0;
		b   = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + b) begin
				x   = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// entry k is floor(2^28 * 10^(2^-(k+1))), by repeated floored square roots
	function automatic root_rom_t build_roots();
		root_rom_t   rom;
		logic [63:0] r;
		r = isqrt64(64'd10 << (2 * ROOT_BITS));
		for (int k = 0; k < EXP_FRAC_BITS; k++) begin
			rom[k] = r[31:0];
			r      = isqrt64(r << ROOT_BITS);
		end
		return rom;
	endfunction

	localparam root_rom_t ROOT_ROM = build_roots();

	function automatic logic [29:0] pow_ten(input logic [3:0] n);
		logic [29:0] v;
		case (n)
			4'd0:    v = 30'd1;
			4'd1:    v = 30'd10;
			4'd2:    v = 30'd100;
			4'd3:    v = 30'd1000;
			4'd4:    v = 30'd10000;
			4'd5:    v = 30'd100000;
			4'd6:    v = 30'd1000000;
			4'd7:    v = 30'd10000000;
			4'd8:    v = 30'd100000000;
			4'd9:    v = 30'd1000000000;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/lpa_if.sv =====
// Channel interfaces: sample input, result output and configuration write.
`default_nettype none
interface lpa_in_if;
	import lpa_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface lpa_out_if;
	logic               valid;
	logic               ready;
	logic [31:0]        power_pw;
	logic               power_clamped;
	logic signed [15:0] dbm_centi;
	logic               range_used;
	logic               range_next;
	modport source (output valid, output power_pw, output power_clamped, output dbm_centi,
		output range_used, output range_next, input ready);
	modport sink (input valid, input power_pw, input power_clamped, input dbm_centi,
		input range_used, input range_next, output ready);
endinterface

interface lpa_cfg_if;
	import lpa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/log_detector_power_autorange_core.sv =====
// Top level of the log-detector power meter with automatic range switching.
// Channels: samples (sink) carries one raw ADC code measured in the range
// selected before it; results (source) carries power_pw, power_clamped,
// dbm_centi, range_used and range_next; cfg (sink) writes the eight
// registers by index and is always ready.
// Each result is posted after these steps, in order: product, exponent sum,
// centi-dBm, 16 steps of the 10^f product (one shared 32x32 multiplier, one
// fraction bit per step) and the final 10^n scale. samples.ready is high
// only while the sequencer is idle, so a sample is accepted only once the
// one before it has left its final step.
// A result waits in the output register; the next sample is accepted and
// worked on meanwhile, and the sequencer holds at its final step until the
// output register is free, so a stalled receiver stalls input after one
// more sample.
// Reset clears the sequencer, the output valid flag, selects range 1 and
// loads the register defaults; no clearing pass.
`default_nettype none
module log_detector_power_autorange_core (
	input  logic       clk,
	input  logic       arst_n,
	lpa_in_if.sink     samples,
	lpa_out_if.source  results,
	lpa_cfg_if.sink    cfg
);
	import lpa_pkg::*;

	cfg_t cfg_regs;
	cmd_t cmd;

	lpa_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.regs   (cfg_regs)
	);

	lpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	lpa_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_regs),
		.cmd           (cmd),
		.sample        (samples.sample),
		.power_pw      (results.power_pw),
		.power_clamped (results.power_clamped),
		.dbm_centi     (results.dbm_centi),
		.range_used    (results.range_used),
		.range_next    (results.range_next)
	);

endmodule
`default_nettype wire

// ===== sv/lpa_cfg_regs.sv =====
// Configuration register file for the power meter.
`default_nettype none
module lpa_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	lpa_cfg_if.sink       wr,
	output lpa_pkg::cfg_t regs
);
	import lpa_pkg::*;

	cfg_t regs_q;

	assign wr.ready = 1'b1;
	assign regs     = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.dpc_r0       <= 32'd429497;
			regs_q.dpc_r1       <= 32'd429497;
			regs_q.icpt_r0      <= '0;
			regs_q.icpt_r1      <= '0;
			regs_q.auto_range   <= 1'b1;
			regs_q.manual_range <= 1'b1;
			regs_q.upper_thr    <= 16'd28000;
			regs_q.lower_thr    <= 16'd1950;
		end else if (wr.valid && wr.ready) begin
			case (wr.index)
				REG_DPC_R0:    regs_q.dpc_r0       <= wr.data[31:0];
				REG_DPC_R1:    regs_q.dpc_r1       <= wr.data[31:0];
				REG_ICPT_R0:   regs_q.icpt_r0      <= wr.data[23:0];
				REG_ICPT_R1:   regs_q.icpt_r1      <= wr.data[23:0];
				REG_AUTO:      regs_q.auto_range   <= wr.data[0];
				REG_MANUAL:    regs_q.manual_range <= wr.data[0];
				REG_UPPER_THR: regs_q.upper_thr    <= wr.data[15:0];
				REG_LOWER_THR: regs_q.lower_thr    <= wr.data[15:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/lpa_datapath.sv =====
// Datapath: range selection, exponent sum, centi-dBm, shared multiplier for 10^L, result register.
`default_nettype none
module lpa_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lpa_pkg::cfg_t                   cfg,
	input  lpa_pkg::cmd_t                   cmd,
	input  logic [lpa_pkg::SAMPLE_BITS-1:0] sample,
	output logic [31:0]                     power_pw,
	output logic                            power_clamped,
	output logic signed [15:0]              dbm_centi,
	output logic                            range_used,
	output logic                            range_next
);
	import lpa_pkg::*;

	localparam logic signed [D_W-1:0] DBM_OFS = D_W'(64'd9000 << EXP_FRAC_BITS);

	logic                   sel_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [31:0]            slope_q;
	logic signed [23:0]     icpt_q;
	logic                   used_q;
	logic                   next_q;
	logic [PROD_W-1:0]      prod_q;
	logic signed [LQ_W-1:0] lq_q;
	logic signed [15:0]     dbm_q;
	logic [31:0]            v_q;

	logic [31:0]        power_q;
	logic               clamped_q;
	logic signed [15:0] dbm_out_q;
	logic               used_out_q;
	logic               next_out_q;

	logic                    used;
	logic                    next;
	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [63:0]             mul_p;
	logic signed [SUM_W-1:0] icpt_x;
	logic signed [SUM_W-1:0] prod_x;
	logic signed [SUM_W-1:0] sum;
	logic [N_W-1:0]          n_w;
	logic                    lq_neg;
	logic                    n_big;
	logic [63-ROOT_BITS:0]   scaled;
	logic                    over;
	logic [31:0]             power_n;
	logic                    clamped_n;
	logic signed [D_W-1:0]   lq_x;
	logic signed [D_W-1:0]   d;
	logic [D_W-1:0]          mag;
	logic [Q_W-1:0]          q;
	logic signed [15:0]      dbm_n;
	logic                    frac_bit;

	always_comb begin
		used = cfg.auto_range ? sel_q : cfg.manual_range;
		next = cfg.manual_range;
		if (cfg.auto_range) begin
			next = used;
			if (!used && (CMP_W'(sample) > CMP_W'(cfg.upper_thr))) begin
				next = 1'b1;
			end else if (used && (CMP_W'(sample) < CMP_W'(cfg.lower_thr))) begin
				next = 1'b0;
			end
		end
	end

	assign n_w    = lq_q[LQ_W-2:EXP_FRAC_BITS];
	assign lq_neg = lq_q[LQ_W-1];
	assign n_big  = (n_w >= N_W'(10));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_PROD: begin
				mul_a = 32'(sample_q);
				mul_b = slope_q;
			end
			OP_EXP: begin
				mul_a = v_q;
				mul_b = ROOT_ROM[cmd.k];
			end
			OP_SCALE: begin
				mul_a = {2'b00, pow_ten(n_w[3:0])};
				mul_b = v_q;
			end
			default: ;
		endcase
	end

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	assign icpt_x = SUM_W'(icpt_q);
	assign prod_x = SUM_W'({1'b0, prod_q});
	assign sum    = (icpt_x <<< 16) + prod_x;

	assign frac_bit = lq_q[EXP_FRAC_BITS - 1 - int'(cmd.k)];

	assign scaled = mul_p[63:ROOT_BITS];
	assign over   = |scaled[63-ROOT_BITS:32];

	always_comb begin
		power_n   = scaled[31:0];
		clamped_n = 1'b0;
		if (lq_neg) begin
			power_n = '0;
		end else if (n_big || over) begin
			power_n   = 32'hFFFF_FFFF;
			clamped_n = 1'b1;
		end
	end

	// 1000*L - 9000, L in Q.EXP_FRAC_BITS; 1000 = 1024 - 16 - 8
	always_comb begin
		lq_x = D_W'(lq_q);
		d    = (lq_x <<< 10) - (lq_x <<< 4) - (lq_x <<< 3) - DBM_OFS;
		mag  = d[D_W-1] ? D_W'(-d) : D_W'(d);
		q    = mag[D_W-1:EXP_FRAC_BITS];
		if (d[D_W-1]) begin
			dbm_n = (q > Q_W'(32768)) ? 16'sh8000 : 16'(~q[15:0] + 16'd1);
		end else begin
			dbm_n = (q > Q_W'(32767)) ? 16'sh7FFF : 16'(q[15:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b1;
		end else if (cmd.load) begin
			sel_q <= next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
			slope_q  <= used ? cfg.dpc_r1 : cfg.dpc_r0;
			icpt_q   <= used ? cfg.icpt_r1 : cfg.icpt_r0;
			used_q   <= used;
			next_q   <= next;
		end
		case (cmd.op)
			OP_PROD: prod_q <= mul_p[PROD_W-1:0];
			OP_SUM:  lq_q   <= LQ_W'(sum >>> DROP);
			OP_DBM: begin
				dbm_q <= dbm_n;
				v_q   <= 32'(64'd1 << ROOT_BITS);
			end
			OP_EXP: begin
				if (frac_bit) begin
					v_q <= mul_p[ROOT_BITS+31:ROOT_BITS];
				end
			end
			OP_SCALE: begin
				power_q    <= power_n;
				clamped_q  <= clamped_n;
				dbm_out_q  <= dbm_q;
				used_out_q <= used_q;
				next_out_q <= next_q;
			end
			default: ;
		endcase
	end

	assign power_pw      = power_q;
	assign power_clamped = clamped_q;
	assign dbm_centi     = dbm_out_q;
	assign range_used    = used_out_q;
	assign range_next    = next_out_q;

endmodule
`default_nettype wire

// ===== sv/lpa_ctrl.sv =====
// Controller: sequences one sample through the datapath and owns the result valid flag.
`default_nettype none
module lpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output lpa_pkg::cmd_t cmd
);
	import lpa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROD,
		S_SUM,
		S_DBM,
		S_EXP,
		S_SCALE
	} state_t;

	state_t         state_q;
	logic [K_W-1:0] k_q;
	logic           out_valid_q;
	logic           out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.k    = k_q;
		case (state_q)
			S_PROD:  cmd.op = OP_PROD;
			S_SUM:   cmd.op = OP_SUM;
			S_DBM:   cmd.op = OP_DBM;
			S_EXP:   cmd.op = OP_EXP;
			S_SCALE: cmd.op = out_free ? OP_SCALE : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && (state_q != S_SCALE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PROD;
					end
				end
				S_PROD: state_q <= S_SUM;
				S_SUM:  state_q <= S_DBM;
				S_DBM: begin
					k_q     <= '0;
					state_q <= S_EXP;
				end
				S_EXP: begin
					k_q <= k_q + 1'b1;
					if (k_q == K_LAST) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_valid_from_scale: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_SCALE))
		else $error("result valid rose outside the final step");

	a_exp_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXP && $past(state_q == S_DBM)) |-> (k_q == '0))
		else $error("exponent iteration did not start at bit zero");

	a_scale_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCALE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not posted");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SCALE) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while pending");

endmodule
`default_nettype wire
